// ----- hw/rtl/wvad_pkg.sv -----
// Package for the wind vane averager and direction decoder.
// Holds field widths, reset values and the fixed vane range table.
// No dependencies; every other file of the block but wvad_divider refers to it.
package wvad_pkg;

	localparam int unsigned SAMPLE_W       = 10;
	localparam int unsigned DIR_W          = 5;
	localparam int unsigned MAG_W          = 4;
	localparam int unsigned WINDOW_DEFAULT = 10;
	localparam int unsigned VANE_RANGES    = 15;
	localparam int unsigned RANGE_IDX_W    = $clog2(VANE_RANGES);

	localparam logic [SAMPLE_W-1:0] REJECT_RESET = 10'd1000;

	typedef struct packed {
		logic        [SAMPLE_W-1:0] lo;
		logic        [SAMPLE_W-1:0] hi;
		logic signed [DIR_W-1:0]    dir;
	} vane_range_t;

	localparam vane_range_t VANE_TABLE [VANE_RANGES] = '{
		'{lo: 10'd750, hi: 10'd800, dir:  5'sd0},
		'{lo: 10'd690, hi: 10'd730, dir: -5'sd1},
		'{lo: 10'd865, hi: 10'd885, dir: -5'sd2},
		'{lo: 10'd815, hi: 10'd850, dir: -5'sd3},
		'{lo: 10'd925, hi: 10'd945, dir: -5'sd4},
		'{lo: 10'd590, hi: 10'd615, dir: -5'sd5},
		'{lo: 10'd605, hi: 10'd625, dir: -5'sd6},
		'{lo: 10'd240, hi: 10'd260, dir: -5'sd7},
		'{lo: 10'd265, hi: 10'd285, dir:  5'sd8},
		'{lo: 10'd120, hi: 10'd135, dir:  5'sd7},
		'{lo: 10'd155, hi: 10'd175, dir:  5'sd6},
		'{lo: 10'd50,  hi: 10'd74,  dir:  5'sd5},
		'{lo: 10'd65,  hi: 10'd85,  dir:  5'sd4},
		'{lo: 10'd435, hi: 10'd465, dir:  5'sd2},
		'{lo: 10'd400, hi: 10'd420, dir:  5'sd1}
	};

endpackage

// ----- hw/rtl/wvad_sample_if.sv -----
// Valid/ready channel that carries one vane ADC sample per transaction.
// Depends on wvad_pkg for the sample width.
interface wvad_sample_if;
	logic                          valid;
	logic                          ready;
	logic [wvad_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ----- hw/rtl/wvad_result_if.sv -----
// Valid/ready channel that carries one decoded direction and window average.
// Depends on wvad_pkg for the field widths.
interface wvad_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [wvad_pkg::DIR_W-1:0] direction_signed;
	logic [wvad_pkg::MAG_W-1:0]        direction_magnitude;
	logic [wvad_pkg::SAMPLE_W-1:0]     average_raw;

	modport source (output valid, output direction_signed, output direction_magnitude,
		output average_raw, input ready);
	modport sink (input valid, input direction_signed, input direction_magnitude,
		input average_raw, output ready);
endinterface

// ----- hw/rtl/wvad_divider.sv -----
// Restoring unsigned divider, one quotient bit per clock cycle.
// Standalone, no package dependency.
module wvad_divider #(
	parameter int unsigned NUM_W = 16,
	parameter int unsigned DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int unsigned STEP_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] div_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic           ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign ge      = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/wind_vane_average_and_decode.sv -----
// Wind vane window averager and direction decoder, top level.
// Depends on wvad_pkg, wvad_sample_if, wvad_result_if and wvad_divider.
//
// Usage: vane samples arrive on the vane channel, one per transaction. A sample
// above the reject_q register (written through cfg_we/cfg_wdata, reset
// value 1000) is dropped from the average but still counts toward the window.
// After WINDOW samples the window closes and one result goes out on the
// heading channel: the signed direction in 22.5 degree steps, its magnitude,
// and the truncated average. Other samples produce no result.
// Flow: a sample that does not close a window leaves vane ready for the next.
// A closing sample starts the bit-serial divider (skipped when no sample was
// kept), then a scan of the fifteen-entry range table, one entry per cycle,
// then a load of the output register; vane is not ready again until that
// load is done.
// The result sits in an output register; while the receiver stalls, samples
// keep being taken, and only a following window close waits for it.
// Reset clears the window, the held average and direction, and the output.
module wind_vane_average_and_decode #(
	parameter int unsigned WINDOW = wvad_pkg::WINDOW_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wvad_pkg::SAMPLE_W-1:0] cfg_wdata,
	wvad_sample_if.sink                   vane,
	wvad_result_if.source                 heading
);

	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam int unsigned SUM_W = wvad_pkg::SAMPLE_W + CNT_W;
	localparam int unsigned SW    = wvad_pkg::SAMPLE_W;
	localparam int unsigned DW    = wvad_pkg::DIR_W;
	localparam int unsigned IW    = wvad_pkg::RANGE_IDX_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [SW-1:0]         reject_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      pos_q;
	logic [SW-1:0]         prev_avg_q;
	logic signed [DW-1:0]  held_dir_q;
	logic [SW-1:0]         avg_q;
	logic signed [DW-1:0]  dir_q;
	logic [IW-1:0]         idx_q;
	logic                  out_valid_q;
	logic signed [DW-1:0]  out_dir_q;
	logic [wvad_pkg::MAG_W-1:0] out_mag_q;
	logic [SW-1:0]         out_avg_q;

	logic                  take;
	logic                  keep;
	logic [SUM_W-1:0]      sum_next;
	logic [CNT_W-1:0]      count_next;
	logic [CNT_W-1:0]      pos_next;
	logic                  closing;
	logic                  div_done;
	logic [SUM_W-1:0]      div_quotient;
	logic                  out_free;
	logic                  hit;
	logic [DW-1:0]         dir_neg;
	wvad_pkg::vane_range_t entry;

	assign vane.ready = (state_q == S_IDLE);
	assign take       = vane.valid && vane.ready;
	assign keep       = vane.sample <= reject_q;
	assign sum_next   = sum_q + (keep ? SUM_W'(vane.sample) : SUM_W'(0));
	assign count_next = count_q + (keep ? CNT_W'(1) : CNT_W'(0));
	assign pos_next   = pos_q + CNT_W'(1);
	assign closing    = pos_next == CNT_W'(WINDOW);
	assign out_free   = !out_valid_q || heading.ready;
	assign entry      = wvad_pkg::VANE_TABLE[idx_q];
	assign hit        = (avg_q >= entry.lo) && (avg_q <= entry.hi);
	assign dir_neg    = DW'(-dir_q);

	wvad_divider #(
		.NUM_W(SUM_W),
		.DEN_W(CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take && closing && (count_next != '0)),
		.dividend (sum_next),
		.divisor  (count_next),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_q <= wvad_pkg::REJECT_RESET;
		end else if (cfg_we) begin
			reject_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			prev_avg_q  <= '0;
			held_dir_q  <= '0;
			avg_q       <= '0;
			dir_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_dir_q   <= '0;
			out_mag_q   <= '0;
			out_avg_q   <= '0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				out_dir_q   <= dir_q;
				out_mag_q   <= dir_q[DW-1] ? dir_neg[wvad_pkg::MAG_W-1:0]
					: dir_q[wvad_pkg::MAG_W-1:0];
				out_avg_q   <= avg_q;
			end else if (heading.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (closing) begin
							sum_q   <= '0;
							count_q <= '0;
							pos_q   <= '0;
							dir_q   <= held_dir_q;
							idx_q   <= '0;
							if (count_next == '0) begin
								avg_q   <= prev_avg_q;
								state_q <= S_SCAN;
							end else begin
								state_q <= S_DIV;
							end
						end else begin
							sum_q   <= sum_next;
							count_q <= count_next;
							pos_q   <= pos_next;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						avg_q   <= div_quotient[SW-1:0];
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						dir_q <= entry.dir;
					end
					if (idx_q == IW'(wvad_pkg::VANE_RANGES - 1)) begin
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						held_dir_q  <= dir_q;
						prev_avg_q  <= avg_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign heading.valid               = out_valid_q;
	assign heading.direction_signed    = out_dir_q;
	assign heading.direction_magnitude = out_mag_q;
	assign heading.average_raw         = out_avg_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the wind vane averager and direction decoder.
// Depends on wvad_pkg, wvad_sample_if, wvad_result_if and the block's RTL.
module tb_top;

	localparam int unsigned SAMPLE_W    = wvad_pkg::SAMPLE_W;
	localparam int unsigned DIR_W       = wvad_pkg::DIR_W;
	localparam int unsigned MAG_W       = wvad_pkg::MAG_W;
	localparam logic [SAMPLE_W-1:0] REJECT_RESET = wvad_pkg::REJECT_RESET;
	localparam int unsigned WIN         = wvad_pkg::WINDOW_DEFAULT;
	localparam int          DRAIN       = 64;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          REPORT_MAX  = 10;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir;
		logic [MAG_W-1:0]        mag;
		logic [SAMPLE_W-1:0]     avg;
	} heading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [SAMPLE_W-1:0] cfg_wdata;

	wvad_sample_if vane_ch ();
	wvad_result_if heading_ch ();

	wind_vane_average_and_decode #(.WINDOW(WIN)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.vane     (vane_ch),
		.heading  (heading_ch)
	);

	int range_lo  [15] = '{750, 690, 865, 815, 925, 590, 605, 240, 265, 120, 155, 50, 65, 435, 400};
	int range_hi  [15] = '{800, 730, 885, 850, 945, 615, 625, 260, 285, 135, 175, 74, 85, 465, 420};
	int range_dir [15] = '{0, -1, -2, -3, -4, -5, -6, -7, 8, 7, 6, 5, 4, 2, 1};

	logic [SAMPLE_W-1:0]     reject_level = REJECT_RESET;
	logic [15:0]             acc_sum      = '0;
	logic [6:0]              kept_count   = '0;
	logic [6:0]              win_pos      = '0;
	logic [SAMPLE_W-1:0]     last_avg     = '0;
	logic signed [DIR_W-1:0] last_dir     = '0;

	heading_t pending_headings [$];
	heading_t want_heading;
	heading_t got_heading;

	int mismatch_count  = 0;
	int headings_seen   = 0;
	int sent_total      = 0;
	int cycle_count     = 0;
	int stall_left      = 0;
	int hold_off_cycles = 0;
	bit send_idle_en    = 1'b0;
	bit recv_idle_en    = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic decode_vane_sample(input logic [SAMPLE_W-1:0] s);
		heading_t h;
		logic [15:0] quotient;
		logic signed [DIR_W-1:0] d;
		logic signed [DIR_W-1:0] abs_d;
		logic [SAMPLE_W-1:0] a;
		int i;
		if (s <= reject_level) begin
			acc_sum = acc_sum + 16'(s);
			kept_count = kept_count + 1'b1;
		end
		win_pos = win_pos + 1'b1;
		if (win_pos >= WIN) begin
			if (kept_count != 0) begin
				quotient = acc_sum / {9'd0, kept_count};
				a = quotient[SAMPLE_W-1:0];
			end else begin
				a = last_avg;
			end
			d = last_dir;
			for (i = 0; i < 15; i++) begin
				if (a >= range_lo[i] && a <= range_hi[i])
					d = DIR_W'(range_dir[i]);
			end
			abs_d = (d < 0) ? -d : d;
			h.dir = d;
			h.mag = abs_d[MAG_W-1:0];
			h.avg = a;
			pending_headings.push_back(h);
			last_dir = d;
			last_avg = a;
			acc_sum = '0;
			kept_count = '0;
			win_pos = '0;
		end
	endtask

	task automatic report_mismatch(input bit have_want, input heading_t want, input heading_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			if (have_want)
				$display("mismatch at %0t: expected dir %0d mag %0d avg %0d, got dir %0d mag %0d avg %0d",
					$realtime, want.dir, want.mag, want.avg, got.dir, got.mag, got.avg);
			else
				$display("mismatch at %0t: no result expected, got dir %0d mag %0d avg %0d",
					$realtime, got.dir, got.mag, got.avg);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && vane_ch.valid && vane_ch.ready)
			decode_vane_sample(vane_ch.sample);
	end

	always @(posedge clk) begin
		if (arst_n && heading_ch.valid && heading_ch.ready) begin
			got_heading.dir = heading_ch.direction_signed;
			got_heading.mag = heading_ch.direction_magnitude;
			got_heading.avg = heading_ch.average_raw;
			headings_seen++;
			if (pending_headings.size() == 0) begin
				report_mismatch(1'b0, got_heading, got_heading);
			end else begin
				want_heading = pending_headings.pop_front();
				if (want_heading !== got_heading)
					report_mismatch(1'b1, want_heading, got_heading);
			end
		end
	end

	initial begin
		heading_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				heading_ch.ready <= 1'b0;
				hold_off_cycles--;
			end else if (stall_left > 0) begin
				heading_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				heading_ch.ready <= 1'b1;
				if (recv_idle_en)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		int gap;
		vane_ch.valid <= 1'b1;
		vane_ch.sample <= value;
		@(posedge clk);
		while (!vane_ch.ready)
			@(posedge clk);
		sent_total++;
		if (send_idle_en) begin
			gap = pick_gap();
			if (gap > 0) begin
				vane_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle_block();
		vane_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_headings.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_reject_level(input logic [SAMPLE_W-1:0] level);
		settle_block();
		cfg_we <= 1'b1;
		cfg_wdata <= level;
		reject_level = level;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_window();
		int n;
		int mode;
		int idx;
		int target;
		int v;
		int k;
		n = WIN - (sent_total % WIN);
		mode = $urandom_range(0, 99);
		idx = $urandom_range(0, 14);
		target = $urandom_range(range_lo[idx] - 2, range_hi[idx] + 2);
		for (k = 0; k < n; k++) begin
			if (mode < 65) begin
				if (reject_level < 1023 && $urandom_range(0, 7) == 0)
					v = $urandom_range(reject_level + 1, 1023);
				else
					v = target + $urandom_range(0, 6) - 3;
			end else if (mode < 78 && reject_level < 1023) begin
				v = $urandom_range(reject_level + 1, 1023);
			end else begin
				v = $urandom_range(0, 1023);
			end
			send_sample(v[SAMPLE_W-1:0]);
		end
	endtask

	// The first window keeps nothing, so it repeats the zero average and
	// matches no range; the second lands where two ranges overlap; the third
	// keeps a sample equal to the threshold and again matches nothing.
	task automatic test_directed();
		logic [SAMPLE_W-1:0] empty_win [10] = '{1023, 1001, 1023, 1010, 1001,
			1023, 1002, 1015, 1023, 1001};
		int k;
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		for (k = 0; k < 10; k++)
			send_sample(empty_win[k]);
		for (k = 0; k < 10; k++)
			send_sample((k == 8) ? 10'd1023 : 10'd610);
		for (k = 0; k < 10; k++)
			send_sample((k == 9) ? 10'd1023 : ((k % 2 == 0) ? 10'd1000 : 10'd0));
		settle_block();
	endtask

	task automatic test_reject_floor();
		int w;
		int k;
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		set_reject_level(10'd0);
		for (w = 0; w < 4; w++) begin
			for (k = 0; k < WIN; k++) begin
				if (w != 3 && $urandom_range(0, 2) == 0)
					send_sample(10'd0);
				else
					send_sample(SAMPLE_W'($urandom_range(1, 1023)));
			end
		end
	endtask

	task automatic test_random_windows(input logic [SAMPLE_W-1:0] level, input int windows,
		input bit idle_on);
		int w;
		send_idle_en = idle_on;
		recv_idle_en = idle_on;
		set_reject_level(level);
		for (w = 0; w < windows; w++)
			send_window();
	endtask

	task automatic test_backpressure();
		int w;
		set_reject_level(REJECT_RESET);
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		hold_off_cycles = 300;
		for (w = 0; w < 6; w++)
			send_window();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		vane_ch.valid = 1'b0;
		vane_ch.sample = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_reject_floor();
		test_random_windows(10'd1023, 4, 1'b1);
		test_random_windows(REJECT_RESET, 20, 1'b1);
		test_random_windows(10'd620, 10, 1'b1);
		test_random_windows(SAMPLE_W'($urandom_range(200, 900)), 10, 1'b1);
		test_random_windows(REJECT_RESET, 6, 1'b0);
		test_backpressure();
		settle_block();

		$display("Covered %0d samples and %0d window results over thresholds 0 to 1023,",
			sent_total, headings_seen);
		$display("including empty windows, unmatched averages and a long output stall.");
		if (mismatch_count == 0 && pending_headings.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
